FILE: rtl/kcc_pkg.sv
package kcc_pkg;

    // Fixed field widths
    localparam int LEVEL_W  = 4;
    localparam int INDEX_W  = 2;
    localparam int CODE_W   = 2;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 1'b1;

    // Register reset values
    localparam logic [COUNT_W-1:0] LONG_PRESS_RESET   = 16'd100;
    localparam logic [COUNT_W-1:0] CLICK_WINDOW_RESET = 16'd20;

    // Command codes
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Event codes returned on read
    localparam logic [CODE_W-1:0] EV_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] EV_PUSH   = 2'd1;
    localparam logic [CODE_W-1:0] EV_LONG   = 2'd2;
    localparam logic [CODE_W-1:0] EV_DOUBLE = 2'd3;

    // Pending flag positions
    localparam int FLAG_PUSH   = 0;
    localparam int FLAG_LONG   = 1;
    localparam int FLAG_DOUBLE = 2;
    localparam int FLAG_W      = 3;

    // Per-key phase
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_PRESS   = 5'b00010,
        PH_HOLD    = 5'b00100,
        PH_DBLWAIT = 5'b01000,
        PH_RELEASE = 5'b10000
    } phase_t;

    // Timing configuration shared by all lanes
    typedef struct packed {
        logic [COUNT_W-1:0] long_press_ticks;
        logic [COUNT_W-1:0] click_window_ticks;
    } timing_cfg_t;

    // Per-lane control for one accepted request
    typedef struct packed {
        logic scan;
        logic rd;
        logic down;
    } lane_ctrl_t;

endpackage

FILE: rtl/key_click_classifier.sv
// Key click classifier: one lane per key tracks press, hold, double-click
// window and release, and keeps pending single/long/double flags.
// Input channel (s_valid/s_ready): s_cmd scan carries s_key_levels, one
// pressed bit per key; s_cmd read returns and clears the highest-priority
// pending event of key s_key_index (push, then long, then double).
// Result channel (m_valid/m_ready): one m_event_code per read request,
// none for a scan. Config channel (cfg_valid/cfg_ready, always ready):
// index 0 long_press_ticks, index 1 click_window_ticks.
// A read result is in the output register the cycle after the request
// is accepted. One request per cycle while results are taken; all lanes
// update in parallel and the single output register sets the pace.
// When the receiver stalls with a result held, s_ready drops until that
// result is taken; nothing is lost. Reset puts every key in idle, clears
// all counters and flags, empties the output and loads the register
// defaults (100 and 20 ticks).
module key_click_classifier #(
    parameter int KEYS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [kcc_pkg::LEVEL_W-1:0]         s_key_levels,
    input  logic [kcc_pkg::INDEX_W-1:0]         s_key_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kcc_pkg::CODE_W-1:0]          m_event_code,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kcc_pkg::COUNT_W-1:0]         cfg_data
);

    kcc_pkg::timing_cfg_t                  cfg_reg, cfg_next;
    logic                                  s_accept;
    logic                                  rd_accept;
    logic                                  out_free;
    logic [KEYS-1:0][kcc_pkg::CODE_W-1:0]  lane_codes;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                kcc_pkg::REG_LONG_PRESS:   cfg_next.long_press_ticks   = cfg_data;
                kcc_pkg::REG_CLICK_WINDOW: cfg_next.click_window_ticks = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks   <= kcc_pkg::LONG_PRESS_RESET;
            cfg_reg.click_window_ticks <= kcc_pkg::CLICK_WINDOW_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Request handshake
    assign s_ready   = out_free;
    assign s_accept  = s_valid && s_ready;
    assign rd_accept = s_accept && (s_cmd == kcc_pkg::CMD_READ);

    // One lane per key
    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        kcc_pkg::lane_ctrl_t ctrl;

        assign ctrl.scan = s_accept && (s_cmd == kcc_pkg::CMD_SCAN);
        assign ctrl.rd   = rd_accept && (6'(s_key_index) == 6'(k));
        if (k < kcc_pkg::LEVEL_W) begin : g_level
            assign ctrl.down = s_key_levels[k];
        end else begin : g_released
            assign ctrl.down = 1'b0;
        end

        kcc_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cfg        (cfg_reg),
            .ctrl       (ctrl),
            .event_code (lane_codes[k])
        );
    end

    // Merge lane results into the output register
    kcc_merge #(
        .KEYS (KEYS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_accept    (rd_accept),
        .rd_index     (s_key_index),
        .lane_codes   (lane_codes),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code)
    );

endmodule

FILE: rtl/kcc_lane.sv
module kcc_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kcc_pkg::timing_cfg_t          cfg,
    input  kcc_pkg::lane_ctrl_t           ctrl,
    output logic [kcc_pkg::CODE_W-1:0]    event_code
);

    kcc_pkg::phase_t                    phase_reg, phase_next;
    logic [kcc_pkg::COUNT_W-1:0]        hold_reg, hold_next;
    logic [kcc_pkg::COUNT_W-1:0]        gap_reg, gap_next;
    logic [kcc_pkg::FLAG_W-1:0]         pend_reg, pend_next;
    logic [kcc_pkg::COUNT_W-1:0]        hold_inc;
    logic [kcc_pkg::COUNT_W-1:0]        gap_inc;

    // Saturating increments
    assign hold_inc = (hold_reg != '1) ? hold_reg + 1'b1 : hold_reg;
    assign gap_inc  = (gap_reg  != '1) ? gap_reg  + 1'b1 : gap_reg;

    // Report highest-priority pending event
    always_comb begin
        if (pend_reg[kcc_pkg::FLAG_PUSH]) begin
            event_code = kcc_pkg::EV_PUSH;
        end else if (pend_reg[kcc_pkg::FLAG_LONG]) begin
            event_code = kcc_pkg::EV_LONG;
        end else if (pend_reg[kcc_pkg::FLAG_DOUBLE]) begin
            event_code = kcc_pkg::EV_DOUBLE;
        end else begin
            event_code = kcc_pkg::EV_NONE;
        end
    end

    // Advance the key phase on a scan, clear one flag on a read
    always_comb begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        gap_next   = gap_reg;
        pend_next  = pend_reg;
        if (ctrl.scan) begin
            case (phase_reg)
                kcc_pkg::PH_IDLE: begin
                    if (ctrl.down) begin
                        phase_next = kcc_pkg::PH_PRESS;
                    end
                end
                kcc_pkg::PH_PRESS: begin
                    if (ctrl.down) begin
                        phase_next = kcc_pkg::PH_HOLD;
                        hold_next  = '0;
                    end else begin
                        phase_next = kcc_pkg::PH_IDLE;
                    end
                end
                kcc_pkg::PH_HOLD: begin
                    if (ctrl.down) begin
                        hold_next = hold_inc;
                        if (hold_inc >= cfg.long_press_ticks) begin
                            hold_next  = '0;
                            phase_next = kcc_pkg::PH_RELEASE;
                            pend_next[kcc_pkg::FLAG_LONG] = 1'b1;
                        end
                    end else begin
                        hold_next  = '0;
                        gap_next   = '0;
                        phase_next = kcc_pkg::PH_DBLWAIT;
                    end
                end
                kcc_pkg::PH_DBLWAIT: begin
                    gap_next = gap_inc;
                    if (ctrl.down && gap_inc <= cfg.click_window_ticks) begin
                        phase_next = kcc_pkg::PH_RELEASE;
                        gap_next   = '0;
                        pend_next[kcc_pkg::FLAG_DOUBLE] = 1'b1;
                    end else if (!ctrl.down && gap_inc > cfg.click_window_ticks) begin
                        phase_next = kcc_pkg::PH_IDLE;
                        gap_next   = '0;
                        pend_next[kcc_pkg::FLAG_PUSH] = 1'b1;
                    end
                end
                kcc_pkg::PH_RELEASE: begin
                    if (!ctrl.down) begin
                        phase_next = kcc_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase_next = kcc_pkg::PH_IDLE;
                end
            endcase
        end else if (ctrl.rd) begin
            case (event_code)
                kcc_pkg::EV_PUSH:   pend_next[kcc_pkg::FLAG_PUSH]   = 1'b0;
                kcc_pkg::EV_LONG:   pend_next[kcc_pkg::FLAG_LONG]   = 1'b0;
                kcc_pkg::EV_DOUBLE: pend_next[kcc_pkg::FLAG_DOUBLE] = 1'b0;
                default:            pend_next = pend_reg;
            endcase
        end
    end

    // Hold lane state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= kcc_pkg::PH_IDLE;
            hold_reg  <= '0;
            gap_reg   <= '0;
            pend_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            gap_reg   <= gap_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: rtl/kcc_merge.sv
module kcc_merge #(
    parameter int KEYS = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   rd_accept,
    input  logic [kcc_pkg::INDEX_W-1:0]            rd_index,
    input  logic [KEYS-1:0][kcc_pkg::CODE_W-1:0]   lane_codes,
    output logic                                   out_free,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [kcc_pkg::CODE_W-1:0]             m_event_code
);

    localparam int SEL_W = 6;

    logic                          valid_reg, valid_next;
    logic [kcc_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [kcc_pkg::CODE_W-1:0]    sel_code;
    logic [SEL_W-1:0]              sel_index;

    // Pick the addressed lane; an index beyond the lanes reads as no event
    assign sel_index = SEL_W'(rd_index);
    always_comb begin
        sel_code = kcc_pkg::EV_NONE;
        for (int k = 0; k < KEYS; k++) begin
            if (sel_index == SEL_W'(k)) begin
                sel_code = lane_codes[k];
            end
        end
    end

    // Output register frees when empty or being drained
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        code_next  = code_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (rd_accept) begin
            valid_next = 1'b1;
            code_next  = sel_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign m_valid      = valid_reg;
    assign m_event_code = code_reg;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int KEYS = 4;
    localparam int QUIET_LIMIT = 2000;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_cmd;
    logic [kcc_pkg::LEVEL_W-1:0]   s_key_levels;
    logic [kcc_pkg::INDEX_W-1:0]   s_key_index;
    logic                          m_valid;
    logic                          m_ready;
    logic [kcc_pkg::CODE_W-1:0]    m_event_code;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [kcc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [kcc_pkg::COUNT_W-1:0]   cfg_data;

    // Tracked copy of the per-key machines and the timing registers
    kcc_pkg::phase_t             lane_phase [KEYS];
    logic [kcc_pkg::COUNT_W-1:0] lane_hold [KEYS];
    logic [kcc_pkg::COUNT_W-1:0] lane_gap [KEYS];
    logic [kcc_pkg::FLAG_W-1:0]  lane_flags [KEYS];
    logic [kcc_pkg::COUNT_W-1:0] hold_limit;
    logic [kcc_pkg::COUNT_W-1:0] click_window;

    logic [kcc_pkg::CODE_W-1:0]  event_codes_due[$];
    int                          error_count;
    int                          send_idle_pct;
    int                          recv_stall_pct;
    int                          hold_off_len;
    int                          quiet_cycles;
    logic [kcc_pkg::LEVEL_W-1:0] keys_down;

    key_click_classifier #(
        .KEYS(KEYS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_key_levels (s_key_levels),
        .s_key_index  (s_key_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Advance one key by one scan tick
    function automatic void tick_lane(int k, logic down);
        case (lane_phase[k])
            kcc_pkg::PH_IDLE: begin
                if (down)
                    lane_phase[k] = kcc_pkg::PH_PRESS;
            end
            kcc_pkg::PH_PRESS: begin
                if (down) begin
                    lane_phase[k] = kcc_pkg::PH_HOLD;
                    lane_hold[k] = '0;
                end else begin
                    lane_phase[k] = kcc_pkg::PH_IDLE;
                end
            end
            kcc_pkg::PH_HOLD: begin
                if (down) begin
                    if (lane_hold[k] != '1)
                        lane_hold[k] = lane_hold[k] + 1'b1;
                    if (lane_hold[k] >= hold_limit) begin
                        lane_hold[k] = '0;
                        lane_phase[k] = kcc_pkg::PH_RELEASE;
                        lane_flags[k][kcc_pkg::FLAG_LONG] = 1'b1;
                    end
                end else begin
                    lane_hold[k] = '0;
                    lane_gap[k] = '0;
                    lane_phase[k] = kcc_pkg::PH_DBLWAIT;
                end
            end
            kcc_pkg::PH_DBLWAIT: begin
                if (lane_gap[k] != '1)
                    lane_gap[k] = lane_gap[k] + 1'b1;
                if (down && lane_gap[k] <= click_window) begin
                    lane_phase[k] = kcc_pkg::PH_RELEASE;
                    lane_gap[k] = '0;
                    lane_flags[k][kcc_pkg::FLAG_DOUBLE] = 1'b1;
                end else if (!down && lane_gap[k] > click_window) begin
                    lane_phase[k] = kcc_pkg::PH_IDLE;
                    lane_gap[k] = '0;
                    lane_flags[k][kcc_pkg::FLAG_PUSH] = 1'b1;
                end
            end
            kcc_pkg::PH_RELEASE: begin
                if (!down)
                    lane_phase[k] = kcc_pkg::PH_IDLE;
            end
            default: begin
                lane_phase[k] = kcc_pkg::PH_IDLE;
            end
        endcase
    endfunction

    // Take the highest-priority pending event of one key and clear it
    function automatic logic [kcc_pkg::CODE_W-1:0] take_event(int k);
        if (k >= KEYS)
            return kcc_pkg::EV_NONE;
        if (lane_flags[k][kcc_pkg::FLAG_PUSH]) begin
            lane_flags[k][kcc_pkg::FLAG_PUSH] = 1'b0;
            return kcc_pkg::EV_PUSH;
        end
        if (lane_flags[k][kcc_pkg::FLAG_LONG]) begin
            lane_flags[k][kcc_pkg::FLAG_LONG] = 1'b0;
            return kcc_pkg::EV_LONG;
        end
        if (lane_flags[k][kcc_pkg::FLAG_DOUBLE]) begin
            lane_flags[k][kcc_pkg::FLAG_DOUBLE] = 1'b0;
            return kcc_pkg::EV_DOUBLE;
        end
        return kcc_pkg::EV_NONE;
    endfunction

    function automatic void track_request(logic cmd, logic [kcc_pkg::LEVEL_W-1:0] levels,
                                          logic [kcc_pkg::INDEX_W-1:0] index);
        if (cmd == kcc_pkg::CMD_SCAN) begin
            for (int k = 0; k < KEYS; k++)
                tick_lane(k, (k < kcc_pkg::LEVEL_W) ? levels[k] : 1'b0);
        end else begin
            event_codes_due.push_back(take_event(int'(index)));
        end
    endfunction

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input logic cmd, input logic [kcc_pkg::LEVEL_W-1:0] levels,
                                input logic [kcc_pkg::INDEX_W-1:0] index);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_key_levels <= levels;
        s_key_index  <= index;
        do @(posedge aclk); while (!s_ready);
        track_request(cmd, levels, index);
    endtask

    task automatic scan_ticks(input logic [kcc_pkg::LEVEL_W-1:0] levels, input int count);
        for (int i = 0; i < count; i++)
            send_request(kcc_pkg::CMD_SCAN, levels, '0);
    endtask

    task automatic read_key(input int k);
        send_request(kcc_pkg::CMD_READ, kcc_pkg::LEVEL_W'($urandom_range(15)),
                     k[kcc_pkg::INDEX_W-1:0]);
    endtask

    // Write one timing register once the block has drained
    task automatic write_timing(input logic [kcc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [kcc_pkg::COUNT_W-1:0] value);
        s_valid <= 1'b0;
        while (event_codes_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == kcc_pkg::REG_LONG_PRESS)
            hold_limit = value;
        else
            click_window = value;
    endtask

    task automatic set_timing(input logic [kcc_pkg::COUNT_W-1:0] hold_value,
                              input logic [kcc_pkg::COUNT_W-1:0] window_value);
        write_timing(kcc_pkg::REG_LONG_PRESS, hold_value);
        write_timing(kcc_pkg::REG_CLICK_WINDOW, window_value);
    endtask

    // Defaults after reset: key 0 single push on a 20 tick window, key 1 long
    // press after 100 hold ticks
    task automatic test_reset_defaults();
        for (int k = 0; k < KEYS; k++)
            read_key(k);
        scan_ticks(4'b0011, 2);
        scan_ticks(4'b0010, 101);
        scan_ticks(4'b0000, 2);
        for (int k = 0; k < KEYS; k++)
            read_key(k);
        read_key(1);
    endtask

    // Long press and double click on every key, then read them in priority order
    task automatic test_event_priority();
        set_timing(16'd2, 16'd2);
        scan_ticks(4'b0001, 1);
        scan_ticks(4'b0000, 1);
        scan_ticks(4'b1111, 4);
        scan_ticks(4'b0000, 1);
        scan_ticks(4'b1111, 2);
        scan_ticks(4'b0000, 1);
        scan_ticks(4'b1111, 1);
        scan_ticks(4'b0000, 1);
        scan_ticks(4'b1111, 2);
        scan_ticks(4'b0000, 3);
        for (int i = 0; i < 4; i++)
            read_key(3);
        for (int k = 0; k < 3; k++)
            read_key(k);
    endtask

    // Zero hold limit flags on the first hold tick; window at its top never
    // expires
    task automatic test_zero_hold_limit();
        set_timing(16'd0, 16'hFFFF);
        scan_ticks(4'b0101, 3);
        scan_ticks(4'b0000, 1);
        scan_ticks(4'b1010, 2);
        scan_ticks(4'b0000, 200);
        scan_ticks(4'b1010, 1);
        scan_ticks(4'b0000, 1);
        for (int k = 0; k < KEYS; k++)
            read_key(k);
    endtask

    function automatic logic [kcc_pkg::COUNT_W-1:0] pick_ticks();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return kcc_pkg::COUNT_W'($urandom_range(1, 7));
        endcase
    endfunction

    // Random phase: keys mostly follow held/released runs, with reads mixed
    // in and some noise scans
    task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
        int pick;
        set_timing(pick_ticks(), pick_ticks());
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                read_key($urandom_range(KEYS - 1));
            end else if (pick < 38) begin
                send_request(kcc_pkg::CMD_SCAN, kcc_pkg::LEVEL_W'($urandom_range(15)),
                             kcc_pkg::INDEX_W'($urandom_range(3)));
            end else begin
                for (int k = 0; k < kcc_pkg::LEVEL_W; k++)
                    if ($urandom_range(99) < 35)
                        keys_down[k] = ~keys_down[k];
                send_request(kcc_pkg::CMD_SCAN, keys_down,
                             kcc_pkg::INDEX_W'($urandom_range(3)));
            end
        end
    endtask

    // Receiver holds off for a long stretch while reads keep coming
    task automatic test_receiver_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_timing(16'd1, 16'd1);
        scan_ticks(4'b1111, 3);
        scan_ticks(4'b0000, 1);
        scan_ticks(4'b1111, 2);
        scan_ticks(4'b0000, 3);
        hold_off_len = 300;
        for (int i = 0; i < 40; i++)
            read_key($urandom_range(KEYS - 1));
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_len) @(posedge aclk);
                hold_off_len = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result taken with the oldest expected event code
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (event_codes_due.size() == 0) begin
                $error("unexpected result: event_code %0d", m_event_code);
                error_count++;
            end else begin
                logic [kcc_pkg::CODE_W-1:0] due;
                due = event_codes_due.pop_front();
                if (m_event_code !== due) begin
                    $error("event_code mismatch: expected %0d, actual %0d",
                           due, m_event_code);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing is accepted for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("key_click_classifier verification failed");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = kcc_pkg::CMD_SCAN;
        s_key_levels   = '0;
        s_key_index    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = kcc_pkg::REG_LONG_PRESS;
        cfg_data       = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_len   = 0;
        quiet_cycles   = 0;
        keys_down      = '0;
        hold_limit     = kcc_pkg::LONG_PRESS_RESET;
        click_window   = kcc_pkg::CLICK_WINDOW_RESET;
        for (int k = 0; k < KEYS; k++) begin
            lane_phase[k] = kcc_pkg::PH_IDLE;
            lane_hold[k]  = '0;
            lane_gap[k]   = '0;
            lane_flags[k] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_event_priority();
        test_zero_hold_limit();
        run_random_phase(230, 0, 0);
        run_random_phase(230, 61, 0);
        run_random_phase(230, 0, 61);
        run_random_phase(230, 23, 23);
        test_receiver_backpressure();

        // Drain, then let any stray result show up
        s_valid <= 1'b0;
        while (event_codes_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("key_click_classifier verification clean");
        else
            $display("key_click_classifier verification failed");
        $finish;
    end

endmodule
